// ----- rtl/core/srtl_pkg.sv -----
// ----------------------------------------------------------------------------
// srtl_pkg
// Shared constants for the sorted region table: sizing defaults, field
// widths, command codes and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package srtl_pkg;

  // Default sizing
  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_ADDR_BITS   = 39;

  // Fixed field widths
  localparam int SLOT_W   = 4;
  localparam int FLAGS_W  = 8;
  localparam int STATUS_W = 3;

  typedef logic [STATUS_W-1:0] status_t;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Result status codes
  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_MISS    = 3'd1;
  localparam status_t ST_EMPTY   = 3'd2;
  localparam status_t ST_OVERLAP = 3'd3;
  localparam status_t ST_FULL    = 3'd4;

endpackage

`default_nettype wire

// ----- rtl/core/sorted_region_table_lookup_core.sv -----
// ----------------------------------------------------------------------------
// sorted_region_table_lookup_core
// Table of half-open address regions kept sorted by start address in one
// synchronous memory, with insert and lookup commands and a last-hit cache.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one command item: cmd selects
//   insert (region_start, region_end, region_flags) or lookup (lookup_addr).
//   Output channel (out_valid/out_stall) returns one result item per command:
//   status, slot and, on a lookup hit, the found region.
//   Items are handled one at a time; the scan and the shift walk the single
//   read port of the region memory one entry per cycle.
//   The next item is taken the cycle after the result moves to the output
//   register, while that result may still wait there.
//   Reset (rst, synchronous) empties the table and drops the cached slot; the
//   memory itself needs no clearing pass.
//   While out_stall is high the result holds; a finished item waits in the
//   staging state and no new item is taken until it moves to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_region_table_lookup_core
  import srtl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int ADDR_BITS   = DEF_ADDR_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // command items
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 cmd,
  input  wire logic [ADDR_BITS-1:0] region_start,
  input  wire logic [ADDR_BITS:0]   region_end,
  input  wire logic [FLAGS_W-1:0]   region_flags,
  input  wire logic [ADDR_BITS-1:0] lookup_addr,
  // result items
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output status_t                   status,
  output logic [SLOT_W-1:0]         slot,
  output logic [ADDR_BITS-1:0]      found_start,
  output logic [ADDR_BITS:0]        found_end,
  output logic [FLAGS_W-1:0]        found_flags
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS:0]   limit;
    logic [FLAGS_W-1:0]   flags;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_PROBE, S_PCHK, S_SCAN, S_CHECK, S_SHIFT, S_DONE
  } state_t;

  state_t state;

  // Region memory
  entry_t mem [TABLE_DEPTH];
  entry_t rdata;
  logic [IDX_W-1:0] rd_addr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;

  // Latched command
  logic                 cmd_q;
  logic [ADDR_BITS-1:0] s_q;
  logic [ADDR_BITS:0]   e_q;
  logic [FLAGS_W-1:0]   flags_q;
  logic [ADDR_BITS-1:0] a_q;

  // Table state
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] lh_idx;
  logic             lh_valid;

  // Scan and shift bookkeeping
  logic [CNT_W-1:0]     scan_idx;
  logic                 pend;
  logic [IDX_W-1:0]     cmp_idx;
  logic [ADDR_BITS:0]   prev_end;
  logic                 prev_seen;
  logic [ADDR_BITS-1:0] next_start;
  logic                 found_q;
  logic [CNT_W-1:0]     p_idx;
  logic [CNT_W-1:0]     sh_rd;
  logic                 sh_pend;
  logic [IDX_W-1:0]     sh_wr;

  // Staged result
  status_t              res_status;
  logic [SLOT_W-1:0]    res_slot;
  logic [ADDR_BITS-1:0] res_start;
  logic [ADDR_BITS:0]   res_end;
  logic [FLAGS_W-1:0]   res_flags;

  logic             holds;
  logic             scan_stop;
  logic             overlap;
  logic             sh_more;
  logic [CNT_W-1:0] sh_rd_m1;
  logic             wr_new;
  logic             load_out;

  // Compare the read entry against the latched command
  assign holds     = (rdata.base <= a_q) && ({1'b0, a_q} < rdata.limit);
  assign scan_stop = pend && ((cmd_q == CMD_LOOKUP) ? holds : (rdata.base > s_q));
  assign overlap   = (prev_seen && (prev_end > {1'b0, s_q})) ||
                     (found_q && (e_q > {1'b0, next_start}));
  assign sh_more   = (sh_rd > p_idx);
  assign sh_rd_m1  = sh_rd - CNT_W'(1);
  assign wr_new    = (state == S_SHIFT) && !sh_more && !sh_pend;
  assign load_out  = (state == S_DONE) && (!out_valid || !out_stall);
  assign in_stall  = rst || (state != S_IDLE);

  // Select memory read address and write port
  always_comb begin
    case (state)
      S_PROBE: rd_addr = lh_idx;
      S_SHIFT: rd_addr = sh_rd_m1[IDX_W-1:0];
      default: rd_addr = scan_idx[IDX_W-1:0];
    endcase
    we    = 1'b0;
    waddr = sh_wr;
    wdata = rdata;
    if (state == S_SHIFT && sh_pend) begin
      we = 1'b1;
    end else if (wr_new) begin
      we          = 1'b1;
      waddr       = p_idx[IDX_W-1:0];
      wdata.base  = s_q;
      wdata.limit = e_q;
      wdata.flags = flags_q;
    end
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Memory read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
  end

  // Control sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      lh_idx    <= '0;
      lh_valid  <= 1'b0;
      pend      <= 1'b0;
      sh_pend   <= 1'b0;
    end else begin
      // Load a staged result, or drop one the receiver took
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q     <= cmd;
            s_q       <= region_start;
            e_q       <= region_end;
            flags_q   <= region_flags;
            a_q       <= lookup_addr;
            scan_idx  <= '0;
            pend      <= 1'b0;
            prev_seen <= 1'b0;
            res_slot  <= '0;
            res_start <= '0;
            res_end   <= '0;
            res_flags <= '0;
            if (cmd == CMD_INSERT) begin
              if ({1'b0, region_start} >= region_end) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end else if (lh_valid) begin
              state <= S_PROBE;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_PROBE: begin
          state <= S_PCHK;
        end

        // Try the cached slot before scanning
        S_PCHK: begin
          if (holds) begin
            res_status <= ST_OK;
            res_slot   <= SLOT_W'(lh_idx);
            res_start  <= rdata.base;
            res_end    <= rdata.limit;
            res_flags  <= rdata.flags;
            state      <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end

        // Walk entries from slot 0, one read issued per cycle
        S_SCAN: begin
          if (pend && !scan_stop) begin
            prev_end  <= rdata.limit;
            prev_seen <= 1'b1;
          end
          if (scan_stop) begin
            pend <= 1'b0;
            if (cmd_q == CMD_LOOKUP) begin
              res_status <= ST_OK;
              res_slot   <= SLOT_W'(cmp_idx);
              res_start  <= rdata.base;
              res_end    <= rdata.limit;
              res_flags  <= rdata.flags;
              lh_idx     <= cmp_idx;
              lh_valid   <= 1'b1;
              state      <= S_DONE;
            end else begin
              p_idx      <= CNT_W'(cmp_idx);
              found_q    <= 1'b1;
              next_start <= rdata.base;
              state      <= S_CHECK;
            end
          end else if (scan_idx == count) begin
            pend <= 1'b0;
            if (cmd_q == CMD_LOOKUP) begin
              res_status <= ST_MISS;
              state      <= S_DONE;
            end else begin
              p_idx   <= count;
              found_q <= 1'b0;
              state   <= S_CHECK;
            end
          end else begin
            pend     <= 1'b1;
            cmp_idx  <= scan_idx[IDX_W-1:0];
            scan_idx <= scan_idx + CNT_W'(1);
          end
        end

        // Check neighbors and capacity
        S_CHECK: begin
          if (overlap) begin
            res_status <= ST_OVERLAP;
            state      <= S_DONE;
          end else if (count == CNT_W'(TABLE_DEPTH)) begin
            res_status <= ST_FULL;
            state      <= S_DONE;
          end else begin
            sh_rd   <= count;
            sh_pend <= 1'b0;
            state   <= S_SHIFT;
          end
        end

        // Move entries up from the top, then write the new one
        S_SHIFT: begin
          if (sh_more) begin
            sh_rd   <= sh_rd_m1;
            sh_wr   <= sh_rd[IDX_W-1:0];
            sh_pend <= 1'b1;
          end else if (sh_pend) begin
            sh_pend <= 1'b0;
          end else begin
            count <= count + CNT_W'(1);
            if (lh_valid && (CNT_W'(lh_idx) >= p_idx)) begin
              lh_idx <= lh_idx + IDX_W'(1);
            end
            res_status <= ST_OK;
            res_slot   <= SLOT_W'(p_idx);
            state      <= S_DONE;
          end
        end

        // Hand the staged result to the output register
        S_DONE: begin
          if (load_out) begin
            status      <= res_status;
            slot        <= res_slot;
            found_start <= res_start;
            found_end   <= res_end;
            found_flags <= res_flags;
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_cache_in_table: assert property (@(posedge clk) disable iff (rst)
    lh_valid |-> (CNT_W'(lh_idx) < count))
    else $error("cached slot outside the filled table");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result presented without a staged item");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    wr_new |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert write did not grow the table");

endmodule

`default_nettype wire

// ----- sim/sorted_region_table_lookup_core_test.sv -----
// ----------------------------------------------------------------------------
// sorted_region_table_lookup_core_test
// Self-checking bench for the sorted region table. A directed opening fills
// the table through every insert outcome and lookup path. Random lookups and
// insert attempts follow under four idling patterns and one long output
// hold-off. Each result item is checked against a table model kept here.
// ----------------------------------------------------------------------------
module sorted_region_table_lookup_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srtl_pkg::*;

  localparam int AW    = DEF_ADDR_BITS;
  localparam int DEPTH = DEF_TABLE_DEPTH;

  // Address space is split into DEPTH strides for the directed regions
  localparam longint unsigned SPAN   = 64'd1 << AW;
  localparam longint unsigned STRIDE = SPAN / DEPTH;

  // Watchdog limit, well above the worst run
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          TAIL_CYCLES = 100;
  localparam int          HOLD_AT     = 125;
  localparam int          HOLD_CYCLES = 400;

  typedef logic [AW-1:0]      addr_t;
  typedef logic [AW:0]        bound_t;
  typedef logic [FLAGS_W-1:0] flags_t;
  typedef logic [SLOT_W-1:0]  slot_t;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SENDER_SLOW,
    FLOW_RECEIVER_SLOW,
    FLOW_BOTH_SLOW
  } flow_mode_t;

  typedef struct {
    logic   op;
    addr_t  rstart;
    bound_t rend;
    flags_t rflags;
    addr_t  laddr;
  } cmd_item_t;

  typedef struct {
    status_t st;
    slot_t   sl;
    addr_t   fs;
    bound_t  fe;
    flags_t  ff;
  } region_result_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  logic   cmd = CMD_INSERT;
  addr_t  region_start = '0;
  bound_t region_end = '0;
  flags_t region_flags = '0;
  addr_t  lookup_addr = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  status_t status;
  slot_t   slot;
  addr_t   found_start;
  bound_t  found_end;
  flags_t  found_flags;

  // Model of the region table
  addr_t  map_start [DEPTH];
  bound_t map_end [DEPTH];
  flags_t map_flags [DEPTH];
  int     held_count = 0;
  int     hit_slot = 0;
  bit     hit_valid = 1'b0;

  cmd_item_t      pending_cmds[$];
  region_result_t pending_results[$];
  cmd_item_t      offered;
  region_result_t want;
  flow_mode_t     flow_mode = FLOW_FREE;
  int             recent_slot = 0;
  int             items_taken = 0;
  int             results_seen = 0;
  int             mismatches = 0;
  int unsigned    cycle_count = 0;
  int             hold_left = 0;
  bit             hold_done = 1'b0;

  sorted_region_table_lookup_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .region_start (region_start),
    .region_end   (region_end),
    .region_flags (region_flags),
    .lookup_addr  (lookup_addr),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .slot         (slot),
    .found_start  (found_start),
    .found_end    (found_end),
    .found_flags  (found_flags)
  );

  always #6 clk = ~clk;

  function automatic longint unsigned rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit covers(int idx, addr_t a);
    return map_start[idx] <= a && a < map_end[idx];
  endfunction

  // Apply one command to the table model and return its result item
  function automatic region_result_t resolve_command(cmd_item_t c);
    region_result_t r;
    int pos;
    int i;
    int j;
    r = '{st: ST_OK, sl: '0, fs: '0, fe: '0, ff: '0};
    if (c.op == CMD_INSERT) begin
      if (c.rstart >= c.rend) begin
        r.st = ST_EMPTY;
        return r;
      end
      // place after the last entry whose start is not above the new start
      pos = 0;
      while (pos < held_count && map_start[pos] <= c.rstart) pos++;
      if ((pos > 0 && map_end[pos-1] > c.rstart) ||
          (pos < held_count && c.rend > map_start[pos])) begin
        r.st = ST_OVERLAP;
      end else if (held_count >= DEPTH) begin
        r.st = ST_FULL;
      end else begin
        for (i = held_count; i > pos; i--) begin
          map_start[i] = map_start[i-1];
          map_end[i]   = map_end[i-1];
          map_flags[i] = map_flags[i-1];
        end
        map_start[pos] = c.rstart;
        map_end[pos]   = c.rend;
        map_flags[pos] = c.rflags;
        held_count++;
        // keep the cache on the same region when it shifts up
        if (hit_valid && hit_slot >= pos) hit_slot++;
        r.sl = slot_t'(pos);
      end
    end else begin
      // try the cached slot, then scan from slot 0
      i = -1;
      if (hit_valid && hit_slot < held_count && covers(hit_slot, c.laddr)) i = hit_slot;
      for (j = 0; i < 0 && j < held_count; j++) begin
        if (covers(j, c.laddr)) begin
          i = j;
          hit_slot = j;
          hit_valid = 1'b1;
        end
      end
      if (i < 0) begin
        r.st = ST_MISS;
      end else begin
        r.sl = slot_t'(i);
        r.fs = map_start[i];
        r.fe = map_end[i];
        r.ff = map_flags[i];
      end
    end
    return r;
  endfunction

  // Unused fields carry random junk that the block must ignore
  function automatic cmd_item_t insert_cmd(longint unsigned s, longint unsigned e, flags_t f);
    cmd_item_t c;
    c.op = CMD_INSERT;
    c.rstart = addr_t'(s);
    c.rend = bound_t'(e);
    c.rflags = f;
    c.laddr = addr_t'(rand64());
    return c;
  endfunction

  function automatic cmd_item_t lookup_cmd(longint unsigned a);
    cmd_item_t c;
    c.op = CMD_LOOKUP;
    c.rstart = addr_t'(rand64());
    c.rend = bound_t'(rand64());
    c.rflags = flags_t'($urandom);
    c.laddr = addr_t'(a);
    return c;
  endfunction

  // Directed region k sits inside stride k, but region 1 runs from stride 0 into stride 2 and touches regions 0 and 2
  function automatic cmd_item_t region_cmd(int k);
    longint unsigned s;
    longint unsigned e;
    flags_t f;
    s = k * STRIDE + STRIDE / 4;
    e = k * STRIDE + 3 * STRIDE / 4;
    f = flags_t'(k * 37 + 5);
    if (k == 0) begin
      s = 0;
      f = '0;
    end
    if (k == 1) begin
      s = 3 * STRIDE / 4;
      e = 2 * STRIDE + STRIDE / 4;
    end
    if (k == DEPTH - 1) begin
      e = SPAN;
      f = '1;
    end
    return insert_cmd(s, e, f);
  endfunction

  // Random item aimed at the regions currently held
  function automatic cmd_item_t random_command();
    int j;
    int pick;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned s;
    longint unsigned e;
    pick = $urandom_range(99);
    if (held_count == 0) return lookup_cmd(rand64());
    j = $urandom_range(held_count - 1);
    if ($urandom_range(1) == 0 && recent_slot < held_count) j = recent_slot;
    lo = map_start[j];
    hi = map_end[j];
    // lookups inside a region, often the one asked for last
    if (pick < 45) begin
      recent_slot = j;
      case ($urandom_range(3))
        0: return lookup_cmd(lo);
        1: return lookup_cmd(hi - 1);
        default: return lookup_cmd(lo + rand64() % (hi - lo));
      endcase
    end
    // lookups just outside a region
    if (pick < 55) return lookup_cmd(($urandom_range(1) == 0) ? hi : lo - 1);
    if (pick < 70) return lookup_cmd(rand64());
    // empty range
    if (pick < 76) begin
      s = rand64() % SPAN;
      return insert_cmd(s, s - rand64() % (s + 1), flags_t'($urandom));
    end
    // overlap with a held region from inside or from below
    if (pick < 86) begin
      if ($urandom_range(1) == 0) begin
        s = lo + rand64() % (hi - lo);
        e = s + 1 + rand64() % STRIDE;
      end else begin
        s = lo - rand64() % (lo + 1);
        e = lo + 1 + rand64() % (hi - lo);
      end
      if (e > SPAN) e = SPAN;
      return insert_cmd(s, e, flags_t'($urandom));
    end
    // start right at the end of a region, into the gap after it
    if (pick < 94) begin
      e = hi + 1 + rand64() % (STRIDE / 2);
      if (e > SPAN) e = SPAN;
      return insert_cmd(hi, e, flags_t'($urandom));
    end
    s = rand64() % SPAN;
    e = ($urandom_range(7) == 0) ? SPAN : s + 1 + rand64() % (SPAN - s);
    return insert_cmd(s, e, flags_t'($urandom));
  endfunction

  function automatic bit sender_rests();
    case (flow_mode)
      FLOW_SENDER_SLOW: return $urandom_range(99) < 86;
      FLOW_BOTH_SLOW:   return $urandom_range(99) < 7;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_rests();
    case (flow_mode)
      FLOW_RECEIVER_SLOW: return $urandom_range(99) < 86;
      FLOW_BOTH_SLOW:     return $urandom_range(99) < 7;
      default:            return 1'b0;
    endcase
  endfunction

  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (got_v !== exp_v)
      log_mismatch($sformatf("result %0d %s expected %h got %h",
                             results_seen, name, exp_v, got_v));
  endtask

  task automatic queue_item(cmd_item_t c);
    while (pending_cmds.size() >= 4) @(negedge clk);
    pending_cmds.push_back(c);
  endtask

  // Hold until nothing is queued, offered or outstanding
  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(flow_mode_t mode, int count);
    int n;
    flow_mode = mode;
    for (n = 0; n < count; n++) begin
      while (pending_cmds.size() >= 4) @(negedge clk);
      pending_cmds.push_back(random_command());
    end
    drain();
  endtask

  // Driver: score the item taken at this edge, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_results.push_back(resolve_command(offered));
        items_taken <= items_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() != 0 && !sender_rests()) begin
          offered = pending_cmds.pop_front();
          in_valid     <= 1'b1;
          cmd          <= offered.op;
          region_start <= offered.rstart;
          region_end   <= offered.rend;
          region_flags <= offered.rflags;
          lookup_addr  <= offered.laddr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off, fired once while items keep coming
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && items_taken == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || receiver_rests();
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        log_mismatch($sformatf("result %0d arrived with none expected", results_seen));
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(want.st), 64'(status));
        check_field("slot", 64'(want.sl), 64'(slot));
        check_field("found_start", 64'(want.fs), 64'(found_start));
        check_field("found_end", 64'(want.fe), 64'(found_end));
        check_field("found_flags", 64'(want.ff), 64'(found_flags));
      end
      results_seen++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[sorted_region_table_lookup_core] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    int fill_order [DEPTH];
    fill_order = '{8, 15, 0, 4, 12, 2, 6, 10, 14, 1, 3, 5, 7, 9, 11, 13};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty table miss, then both forms of an empty range
    queue_item(lookup_cmd(0));
    queue_item(insert_cmd(5, 5, 8'h5A));
    queue_item(insert_cmd(SPAN - 1, 0, 8'hA5));
    // insert at the end, scan hit on the top address, then an insert at
    // slot 0 that must carry the cached slot up with it
    queue_item(region_cmd(fill_order[0]));
    queue_item(region_cmd(fill_order[1]));
    queue_item(lookup_cmd(SPAN - 1));
    queue_item(region_cmd(fill_order[2]));
    queue_item(lookup_cmd(SPAN - 1));
    queue_item(region_cmd(fill_order[3]));
    queue_item(region_cmd(fill_order[4]));
    // overlap with the entry before, then with the entry after
    queue_item(insert_cmd(8 * STRIDE + STRIDE / 2, 9 * STRIDE, 8'h11));
    queue_item(insert_cmd(7 * STRIDE, 8 * STRIDE + STRIDE / 4 + 1, 8'h22));
    // fill the table; region 1 touches both neighbors
    for (n = 5; n < DEPTH; n++) queue_item(region_cmd(fill_order[n]));
    // a range that touches both neighbors of a gap finds the table full
    queue_item(insert_cmd(9 * STRIDE + 3 * STRIDE / 4, 10 * STRIDE + STRIDE / 4, 8'h33));
    queue_item(lookup_cmd(0));
    drain();

    run_phase(FLOW_FREE, 350);
    run_phase(FLOW_SENDER_SLOW, 300);
    run_phase(FLOW_RECEIVER_SLOW, 300);
    run_phase(FLOW_BOTH_SLOW, 475);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[sorted_region_table_lookup_core] OK");
    end else begin
      $display("[sorted_region_table_lookup_core] ERROR");
    end
    $finish;
  end

endmodule
